// ===== hdl/delay_queue_timer_server_assert.svh =====
// Assertion macros used by the delay queue timer server RTL.
`ifndef DELAY_QUEUE_TIMER_SERVER_ASSERT_SVH
`define DELAY_QUEUE_TIMER_SERVER_ASSERT_SVH

// Concurrent check sampled on the rising clock edge, off during reset.
`define DQTS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent check that is also live while reset is asserted.
`define DQTS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hdl/dqts_pkg.sv =====
// Package with the constants and types of the delay queue timer server.
package dqts_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int MAX_RESULTS = 32;

    localparam logic [2:0] OP_TICK        = 3'd0;
    localparam logic [2:0] OP_TIME        = 3'd1;
    localparam logic [2:0] OP_DELAY_UNTIL = 3'd2;
    localparam logic [2:0] OP_DELAY       = 3'd3;

    localparam logic [1:0] ST_WOKEN = 2'd0;
    localparam logic [1:0] ST_TIME  = 2'd1;
    localparam logic [1:0] ST_BAD   = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    // One queue entry: wake time in the upper bits so that a plain compare
    // orders by wake time and then by task id.
    typedef struct packed {
        logic [31:0] wake;
        logic [7:0]  id;
    } entry_t;

endpackage

// ===== hdl/dqts_req_if.sv =====
// Request and reply channel interfaces of the delay queue timer server.
interface dqts_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [7:0]  task_id;
    logic [31:0] ticks;

    modport source (output valid, output opcode, output task_id, output ticks, input ready);
    modport sink (input valid, input opcode, input task_id, input ticks, output ready);
endinterface

interface dqts_rsp_if;
    logic        valid;
    logic        ready;
    logic [7:0]  reply_task;
    logic [31:0] reply_value;
    logic [1:0]  status;
    logic        last;

    modport source (output valid, output reply_task, output reply_value, output status,
                    output last, input ready);
    modport sink (input valid, input reply_task, input reply_value, input status,
                  input last, output ready);
endinterface

// ===== hdl/dqts_mem.sv =====
// Sleeper queue memory: one write port, one registered read port.
module dqts_mem #(
    parameter int DEPTH = dqts_pkg::QUEUE_DEPTH
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  dqts_pkg::entry_t         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output dqts_pkg::entry_t         rdata
);

    dqts_pkg::entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hdl/delay_queue_timer_server.sv =====
// Top level of the delay queue timer server.
//
// The block keeps a wrapping 32-bit tick time and a queue of sleeping tasks
// keyed by wake time. Requests arrive as beats on the req channel (opcode,
// task_id, ticks); replies leave as beats on the rsp channel (reply_task,
// reply_value, status, last). A time query, a bad opcode or an insert into a
// full queue gives one reply beat that is valid in the cycle after acceptance.
// A delay or delay-until request into a queue with room gives no beat. A tick
// advances the time and then releases due tasks one at a time. Each release is
// a full scan of the queue memory followed by a decide and a move step, and a
// restart step when another scan is to follow. A tick releases at most
// MAX_RESULTS tasks; it ends when a scan and decide finds nothing due, when the
// queue empties or when that limit is reached. The scan reads the queue memory
// through its single read port. The final beat of a tick carries last. A result
// register sits on the rsp side; a new request is taken only in idle and when
// that register is empty or drains in the same cycle, and when the receiver
// stalls the decide and flush steps hold until the register frees up. Reset
// clears the time and the queue count; the queue memory itself needs no
// clearing since only filled entries are read.
module delay_queue_timer_server #(
    parameter int QUEUE_DEPTH = dqts_pkg::QUEUE_DEPTH,
    parameter int MAX_RESULTS = dqts_pkg::MAX_RESULTS
) (
    input  logic      clk,
    input  logic      rst_n,
    dqts_req_if.sink  req,
    dqts_rsp_if.source rsp
);

    `include "delay_queue_timer_server_assert.svh"

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int NW = $clog2(MAX_RESULTS + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_MOVE   = 3'd3;
    localparam logic [2:0] S_RESCAN = 3'd4;
    localparam logic [2:0] S_FLUSH  = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [31:0]      now_reg, now_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [AW-1:0]    ptr_reg, ptr_next;
    logic [NW-1:0]    nres_reg, nres_next;
    dqts_pkg::entry_t best_reg, best_next;
    logic [AW-1:0]    bidx_reg, bidx_next;
    logic             pend_reg, pend_next;
    logic [7:0]       pend_id_reg, pend_id_next;

    logic             ov_reg, ov_next;
    logic [7:0]       otask_reg, otask_next;
    logic [31:0]      oval_reg, oval_next;
    logic [1:0]       ostat_reg, ostat_next;
    logic             olast_reg, olast_next;

    logic             we, re;
    logic [AW-1:0]    waddr, raddr;
    dqts_pkg::entry_t wdata, rdata;
    logic             slot_free, accept;

    dqts_mem #(.DEPTH(QUEUE_DEPTH)) u_mem (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    // The result register can take a new beat when empty or being drained.
    assign slot_free = !ov_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE) && slot_free;
    assign accept    = req.valid && req.ready;

    assign rsp.valid       = ov_reg;
    assign rsp.reply_task  = otask_reg;
    assign rsp.reply_value = oval_reg;
    assign rsp.status      = ostat_reg;
    assign rsp.last        = olast_reg;

    always_comb
    begin
        state_next   = state_reg;
        now_next     = now_reg;
        count_next   = count_reg;
        ptr_next     = ptr_reg;
        nres_next    = nres_reg;
        best_next    = best_reg;
        bidx_next    = bidx_reg;
        pend_next    = pend_reg;
        pend_id_next = pend_id_reg;
        ov_next      = ov_reg && !rsp.ready;
        otask_next   = otask_reg;
        oval_next    = oval_reg;
        ostat_next   = ostat_reg;
        olast_next   = olast_reg;
        we           = 1'b0;
        waddr        = count_reg[AW-1:0];
        wdata        = '{wake: req.ticks, id: req.task_id};
        re           = 1'b0;
        raddr        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req.opcode)
                        dqts_pkg::OP_TICK:
                        begin
                            now_next  = now_reg + 32'd1;
                            nres_next = '0;
                            pend_next = 1'b0;
                            if (count_reg != '0)
                            begin
                                re         = 1'b1;
                                ptr_next   = '0;
                                state_next = S_SCAN;
                            end
                        end
                        dqts_pkg::OP_TIME:
                        begin
                            ov_next    = 1'b1;
                            otask_next = req.task_id;
                            oval_next  = now_reg;
                            ostat_next = dqts_pkg::ST_TIME;
                            olast_next = 1'b1;
                        end
                        dqts_pkg::OP_DELAY_UNTIL, dqts_pkg::OP_DELAY:
                        begin
                            if (count_reg == CW'(QUEUE_DEPTH))
                            begin
                                ov_next    = 1'b1;
                                otask_next = req.task_id;
                                oval_next  = '0;
                                ostat_next = dqts_pkg::ST_FULL;
                                olast_next = 1'b1;
                            end
                            else
                            begin
                                we = 1'b1;
                                if (req.opcode == dqts_pkg::OP_DELAY)
                                begin
                                    wdata.wake = now_reg + req.ticks;
                                end
                                count_next = count_reg + CW'(1);
                            end
                        end
                        default:
                        begin
                            ov_next    = 1'b1;
                            otask_next = req.task_id;
                            oval_next  = '0;
                            ostat_next = dqts_pkg::ST_BAD;
                            olast_next = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (ptr_reg == '0 || rdata < best_reg)
                begin
                    best_next = rdata;
                    bidx_next = ptr_reg;
                end
                if (CW'(ptr_reg) == count_reg - CW'(1))
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    re       = 1'b1;
                    raddr    = ptr_reg + AW'(1);
                    ptr_next = ptr_reg + AW'(1);
                end
            end
            S_DECIDE:
            begin
                if (best_reg.wake > now_reg)
                begin
                    state_next = pend_reg ? S_FLUSH : S_IDLE;
                end
                else if (!pend_reg || slot_free)
                begin
                    if (pend_reg)
                    begin
                        ov_next    = 1'b1;
                        otask_next = pend_id_reg;
                        oval_next  = '0;
                        ostat_next = dqts_pkg::ST_WOKEN;
                        olast_next = 1'b0;
                    end
                    pend_next    = 1'b1;
                    pend_id_next = best_reg.id;
                    nres_next    = nres_reg + NW'(1);
                    count_next   = count_reg - CW'(1);
                    re           = 1'b1;
                    raddr        = AW'(count_reg - CW'(1));
                    state_next   = S_MOVE;
                end
            end
            S_MOVE:
            begin
                // Fill the hole with the last entry.
                we    = 1'b1;
                waddr = bidx_reg;
                wdata = rdata;
                if (nres_reg == NW'(MAX_RESULTS) || count_reg == '0)
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    state_next = S_RESCAN;
                end
            end
            S_RESCAN:
            begin
                re         = 1'b1;
                ptr_next   = '0;
                state_next = S_SCAN;
            end
            S_FLUSH:
            begin
                if (slot_free)
                begin
                    ov_next    = 1'b1;
                    otask_next = pend_id_reg;
                    oval_next  = '0;
                    ostat_next = dqts_pkg::ST_WOKEN;
                    olast_next = 1'b1;
                    pend_next  = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            now_reg   <= '0;
            count_reg <= '0;
            nres_reg  <= '0;
            pend_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            now_reg   <= now_next;
            count_reg <= count_next;
            nres_reg  <= nres_next;
            pend_reg  <= pend_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg     <= ptr_next;
        best_reg    <= best_next;
        bidx_reg    <= bidx_next;
        pend_id_reg <= pend_id_next;
        otask_reg   <= otask_next;
        oval_reg    <= oval_next;
        ostat_reg   <= ostat_next;
        olast_reg   <= olast_next;
    end

    // The queue never holds more entries than the memory has rows.
    `DQTS_ASSERT(a_count_bound, count_reg <= CW'(QUEUE_DEPTH), "queue count over depth")
    // A tick never releases more tasks than the result limit.
    `DQTS_ASSERT(a_nres_bound, nres_reg <= NW'(MAX_RESULTS), "too many releases in one tick")
    // Requests are only taken between ticks, never in the middle of a scan.
    `DQTS_ASSERT(a_ready_idle, !req.ready || state_reg == S_IDLE, "ready outside idle")
    // A held release always exists when the final beat is flushed.
    `DQTS_ASSERT(a_flush_pend, state_reg != S_FLUSH || pend_reg, "flush without held release")

endmodule
